[design/ors_pkg.sv]
// ----------------------------------------------------------------------------
// ors_pkg - shared codes for the 1-Wire ROM search step
// Request actions, result kinds, status codes and CRC-8 constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ors_pkg;

  // Input actions
  localparam logic [1:0] ACT_BEGIN   = 2'd0;
  localparam logic [1:0] ACT_RESP    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_REQ    = 2'd0;
  localparam logic [1:0] KIND_ROM    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes
  localparam logic [1:0] ST_MORE     = 2'd0;
  localparam logic [1:0] ST_LAST     = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  // Dallas CRC-8, reflected polynomial
  localparam logic [7:0] CRC8_POLY   = 8'h8C;

  // Discrepancy value that marks a broken search
  localparam logic [6:0] DISC_BROKEN = 7'd63;

endpackage

`default_nettype wire

[design/ors_crc8_ser.sv]
// ----------------------------------------------------------------------------
// ors_crc8_ser - bit-serial Dallas CRC-8
// Takes one ROM bit per enabled cycle, LSB of byte 0 first.
// ----------------------------------------------------------------------------
`default_nettype none

module ors_crc8_ser
  import ors_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       clr,
  input  wire logic       en,
  input  wire logic       din,
  output logic [7:0]      crc
);

  logic       fb;
  logic [7:0] crc_next;

  assign fb       = crc[0] ^ din;
  assign crc_next = fb ? ({1'b0, crc[7:1]} ^ CRC8_POLY) : {1'b0, crc[7:1]};

  always_ff @(posedge clk) begin
    if (clr) begin
      crc <= 8'd0;
    end else if (en) begin
      crc <= crc_next;
    end
  end

endmodule

`default_nettype wire

[design/onewire_rom_search_step.sv]
// ----------------------------------------------------------------------------
// onewire_rom_search_step - one pass of the 1-Wire ROM search
// Builds accelerator request bytes from the kept search state, decodes the
// response bytes two bits per cycle and emits the found ROM.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser=action, tdata=response_byte
//  m_*      out  m_tvalid/m_tready   tuser=kind, tdata=byte/status/fam, tlast
//
//  Begin: a finished status if the last device was found; else request bytes
//  built one ROM bit per cycle through the rotating previous-ROM register,
//  four bits per byte, pausing at each of the 16 bytes' output handshakes.
//  Response byte: decoded one bit pair per cycle; the sixteenth adds a
//  check step, then 8 ROM bytes or one status item.
//  Reset clears the search state and the response count at once.
//  A stalled output holds the block; no new request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_rom_search_step
  import ors_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] response_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] data_byte, [9:8] status,
                                      // [13:10] family_discrepancy, [15:14] 0
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_PAIR     = 7'b0000010,
    S_CHECK    = 7'b0000100,
    S_REQ      = 7'b0001000,
    S_REQ_OUT  = 7'b0010000,
    S_ROM_OUT  = 7'b0100000,
    S_STAT_OUT = 7'b1000000
  } state_t;

  state_t      state;

  // search state
  logic [63:0] prev_rom;
  logic [6:0]  ld;
  logic [3:0]  lfd;
  logic        ldf;
  logic [3:0]  cnt;

  // pass accumulators
  logic [7:0]  resp_sr;
  logic [1:0]  pair;
  logic [63:0] rom_acc;
  logic [6:0]  newest;
  logic [3:0]  fam_acc;
  logic        fam_hit;
  logic [7:0]  crc;

  // request builder
  logic [5:0]  bidx;
  logic [7:0]  req_sr;
  logic [2:0]  rom_idx;

  // output register
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_data;
  logic [1:0]  out_status;
  logic [3:0]  out_fd;
  logic        out_last;

  logic        s_acc;
  logic        m_acc;
  logic        flag;
  logic        path;
  logic [5:0]  pidx;
  logic [6:0]  pidx1;
  logic [6:0]  bidx1;
  logic        req_bit;
  logic [7:0]  req_next;
  logic [3:0]  fam_new;
  logic        pass_err;
  logic        crc_clr;
  logic        ldf_new;

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = out_valid && m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {2'b00, out_fd, out_status, out_data};
  assign m_tlast  = out_last;

  assign flag  = resp_sr[0];
  assign path  = resp_sr[1];
  assign pidx  = {cnt, pair};
  assign pidx1 = {1'b0, pidx} + 7'd1;

  assign bidx1    = {1'b0, bidx} + 7'd1;
  assign req_bit  = (ld != 7'd0) && ((bidx1 < ld) ? prev_rom[0] : (bidx1 == ld));
  assign req_next = {req_bit, 1'b0, req_sr[7:2]};

  assign fam_new  = fam_hit ? fam_acc : lfd;
  assign pass_err = (crc != 8'd0) || (ld == DISC_BROKEN) || (rom_acc[7:0] == 8'd0);
  // a pass without a begin keeps an earlier last-device mark
  assign ldf_new  = ldf || (newest == 7'd0);

  assign crc_clr  = s_acc && (s_tuser == ACT_RESP) && (cnt == 4'd0);

  ors_crc8_ser u_crc (
    .clk (clk),
    .clr (crc_clr),
    .en  (state == S_PAIR),
    .din (path),
    .crc (crc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prev_rom  <= 64'd0;
      ld        <= 7'd0;
      lfd       <= 4'd0;
      ldf       <= 1'b0;
      cnt       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            case (s_tuser)
              ACT_BEGIN: begin
                cnt <= 4'd0;
                if (ldf) begin
                  ld         <= 7'd0;
                  lfd        <= 4'd0;
                  ldf        <= 1'b0;
                  out_valid  <= 1'b1;
                  out_kind   <= KIND_STATUS;
                  out_data   <= 8'd0;
                  out_status <= ST_FINISHED;
                  out_fd     <= 4'd0;
                  out_last   <= 1'b1;
                  state      <= S_STAT_OUT;
                end else begin
                  bidx  <= 6'd0;
                  state <= S_REQ;
                end
              end
              ACT_RESP: begin
                resp_sr <= s_tdata;
                pair    <= 2'd0;
                if (cnt == 4'd0) begin
                  newest  <= 7'd0;
                  fam_hit <= 1'b0;
                end
                state <= S_PAIR;
              end
              ACT_RESTART: begin
                ld  <= 7'd0;
                lfd <= 4'd0;
                ldf <= 1'b0;
                cnt <= 4'd0;
              end
              default: ;
            endcase
          end
        end
        S_PAIR: begin
          // path bit is the ROM bit; flag set with path clear is a discrepancy
          rom_acc <= {path, rom_acc[63:1]};
          resp_sr <= {2'b00, resp_sr[7:2]};
          if (flag && !path) begin
            newest <= pidx1;
            if (pidx[5:3] == 3'd0) begin
              fam_acc <= pidx1[3:0];
              fam_hit <= 1'b1;
            end
          end
          pair <= pair + 2'd1;
          if (pair == 2'd3) begin
            cnt <= cnt + 4'd1;
            state <= (cnt == 4'd15) ? S_CHECK : S_IDLE;
          end
        end
        S_CHECK: begin
          out_valid <= 1'b1;
          if (pass_err) begin
            ld         <= 7'd0;
            lfd        <= 4'd0;
            ldf        <= 1'b0;
            out_kind   <= KIND_STATUS;
            out_data   <= 8'd0;
            out_status <= ST_ERROR;
            out_fd     <= 4'd0;
            out_last   <= 1'b1;
            state      <= S_STAT_OUT;
          end else begin
            ld         <= newest;
            lfd        <= fam_new;
            ldf        <= ldf_new;
            prev_rom   <= rom_acc;
            out_kind   <= KIND_ROM;
            out_data   <= rom_acc[7:0];
            out_status <= ldf_new ? ST_LAST : ST_MORE;
            out_fd     <= fam_new;
            out_last   <= 1'b0;
            rom_idx    <= 3'd0;
            state      <= S_ROM_OUT;
          end
        end
        S_REQ: begin
          // rotate the previous ROM one bit a cycle, pausing at each output byte; 64 rotations bring it home
          req_sr   <= req_next;
          prev_rom <= {prev_rom[0], prev_rom[63:1]};
          bidx     <= bidx + 6'd1;
          if (bidx[1:0] == 2'd3) begin
            out_valid  <= 1'b1;
            out_kind   <= KIND_REQ;
            out_data   <= req_next;
            out_status <= ST_MORE;
            out_fd     <= 4'd0;
            out_last   <= (bidx[5:2] == 4'd15);
            state      <= S_REQ_OUT;
          end
        end
        S_REQ_OUT: begin
          if (m_acc) begin
            out_valid <= 1'b0;
            state     <= out_last ? S_IDLE : S_REQ;
          end
        end
        S_ROM_OUT: begin
          if (m_acc) begin
            // eight byte rotations restore the kept ROM
            prev_rom <= {prev_rom[7:0], prev_rom[63:8]};
            out_data <= prev_rom[15:8];
            rom_idx  <= rom_idx + 3'd1;
            out_last <= (rom_idx == 3'd6);
            if (rom_idx == 3'd7) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        S_STAT_OUT: begin
          if (m_acc) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input taken while a result is pending");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_STATUS)) |-> m_tlast)
    else $error("status item not marked last");

  a_req_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_REQ)) |-> (m_tdata[13:8] == 6'd0))
    else $error("request item carries status or family bits");

  a_rom_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_ROM)) |-> !m_tdata[9])
    else $error("ROM item with error or finished status");

  a_check_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |=> m_tvalid)
    else $error("pass check produced no result");
`endif

endmodule

`default_nettype wire

[tb/sv/rom_search_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_search_checker - result predictor and comparator for the ROM search step
// Watches both stream channels, keeps its own copy of the search state,
// works out the result items for every accepted request and compares each
// result item field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------

module rom_search_checker
  import ors_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] response_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] status,
                                      // [13:10] family_discrepancy, [15:14] 0
  input  wire logic [1:0]  m_tuser,   // [1:0] kind
  input  wire logic        m_tlast,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] status;
    logic [3:0] fam;
    logic       last;
  } search_item_t;

  search_item_t expected_results[$];

  // Search state kept between passes
  logic [63:0] kept_rom;
  logic [6:0]  disc_pos;
  logic [3:0]  family_disc;
  logic        last_found;
  logic [7:0]  resp_bytes [16];
  logic [4:0]  resp_count;

  task automatic push_item(input logic [1:0] kind, input logic [7:0] data,
                           input logic [1:0] status, input logic [3:0] fam,
                           input logic last);
    search_item_t it;
    it.kind   = kind;
    it.data   = data;
    it.status = status;
    it.fam    = fam;
    it.last   = last;
    expected_results.push_back(it);
  endtask

  task automatic clear_search();
    disc_pos    = '0;
    family_disc = '0;
    last_found  = 1'b0;
  endtask

  task automatic predict_begin();
    logic [127:0] req;
    logic         path;
    resp_count = '0;
    if (last_found) begin
      clear_search();
      push_item(KIND_STATUS, 8'h00, ST_FINISHED, 4'd0, 1'b1);
    end else begin
      req = '0;
      if (disc_pos != 0) begin
        // follow the kept ROM below the discrepancy, force 1 at it, 0 above
        for (int i = 0; i < 64; i++) begin
          if (i + 1 < disc_pos) path = kept_rom[i];
          else if (i + 1 == disc_pos) path = 1'b1;
          else path = 1'b0;
          req[2*i+1] = path;
        end
      end
      for (int k = 0; k < 16; k++)
        push_item(KIND_REQ, req[8*k +: 8], ST_MORE, 4'd0, k == 15);
    end
  endtask

  task automatic decode_pass();
    logic [63:0] rom;
    logic [6:0]  newest;
    logic [3:0]  fam;
    logic [7:0]  crc;
    logic        flag;
    logic        path;
    rom    = '0;
    newest = '0;
    fam    = family_disc;
    crc    = '0;
    for (int i = 0; i < 64; i++) begin
      flag   = resp_bytes[i/4][(2*i) % 8];
      path   = resp_bytes[i/4][(2*i+1) % 8];
      rom[i] = path;
      if (flag && !path) begin
        newest = 7'(i + 1);
        if (i < 8) fam = 4'(i + 1);
      end
    end
    // CRC-8 over all 64 bits, LSB of byte 0 first; a good ROM leaves zero
    for (int b = 0; b < 64; b++)
      crc = (crc[0] ^ rom[b]) ? ((crc >> 1) ^ CRC8_POLY) : (crc >> 1);
    if (crc != 0 || disc_pos == DISC_BROKEN || rom[7:0] == 8'h00) begin
      clear_search();
      push_item(KIND_STATUS, 8'h00, ST_ERROR, 4'd0, 1'b1);
    end else begin
      disc_pos    = newest;
      family_disc = fam;
      if (newest == 0) last_found = 1'b1;
      kept_rom    = rom;
      for (int k = 0; k < 8; k++)
        push_item(KIND_ROM, rom[8*k +: 8], last_found ? ST_LAST : ST_MORE, fam, k == 7);
    end
  endtask

  task automatic predict_response(input logic [7:0] b);
    if (resp_count >= 16) resp_count = '0;
    resp_bytes[resp_count[3:0]] = b;
    resp_count = resp_count + 5'd1;
    if (resp_count == 16) begin
      resp_count = '0;
      decode_pass();
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    search_item_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with nothing outstanding, expected none, got kind %0d tdata %h",
               $time, m_tuser, m_tdata);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("kind", 8'(want.kind), 8'(m_tuser));
      compare_field("data_byte", want.data, m_tdata[7:0]);
      compare_field("status", 8'(want.status), 8'(m_tdata[9:8]));
      compare_field("family_discrepancy", 8'(want.fam), 8'(m_tdata[13:10]));
      compare_field("tdata padding", 8'h00, 8'(m_tdata[15:14]));
      compare_field("last", 8'(want.last), 8'(m_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kept_rom   = '0;
      clear_search();
      resp_count = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      // take the request first so that a same-edge result still sees it queued
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          ACT_BEGIN: begin
            predict_begin();
          end
          ACT_RESP: begin
            predict_response(s_tdata);
          end
          ACT_RESTART: begin
            clear_search();
            resp_count = '0;
          end
          default: begin
          end
        endcase
      end
      if (m_tvalid && m_tready) check_result();
    end
    pending <= expected_results.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the 1-Wire ROM search step
// Drives begin, response, restart and unused requests: a directed opening,
// then mostly well-formed search passes with random ROMs and discrepancy
// flags, mixed with noise and cut-short passes, under three idling phases.
// ----------------------------------------------------------------------------

module tb_top;
  import ors_pkg::*;

  localparam logic [1:0] ACT_UNUSED      = 2'd3;
  localparam int         ITEMS_PER_PHASE = 133;
  localparam int         CYCLE_LIMIT     = 500000;

  // shapes of a random search pass
  localparam int PASS_NORMAL   = 0;
  localparam int PASS_LAST     = 1;
  localparam int PASS_DISC_63  = 2;
  localparam int PASS_CRC_BAD  = 3;
  localparam int PASS_FAM_ZERO = 4;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;   // [7:0] response_byte
  logic [1:0]  s_tuser  = 2'd0;    // [1:0] action
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire [15:0]  m_tdata;            // [7:0] data_byte, [9:8] status,
                                   // [13:10] family_discrepancy, [15:14] 0
  wire [1:0]   m_tuser;            // [1:0] kind
  wire         m_tlast;

  int fail_count;
  int pending;
  int cycles         = 0;
  int items_sent     = 0;
  int passes_run     = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  onewire_rom_search_step uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  rom_search_checker search_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    cycles   <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run timed out after %0d cycles", $time, cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(input logic [1:0] act, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // random ROM with a good CRC byte; optionally zero family or bit 62 low
  function automatic logic [63:0] make_rom(input bit fam_zero, input bit bit62_low);
    logic [63:0] rom;
    logic [7:0]  crc;
    do begin
      rom = {$urandom, $urandom};
      if (fam_zero) rom[7:0] = 8'h00;
      else if (rom[7:0] == 8'h00) rom[7:0] = 8'h28;
      crc = 8'h00;
      for (int b = 0; b < 56; b++)
        crc = (crc[0] ^ rom[b]) ? ((crc >> 1) ^ CRC8_POLY) : (crc >> 1);
      rom[63:56] = crc;
    end while (bit62_low && rom[62]);
    return rom;
  endfunction

  // pack flag (even bit) and path (odd bit) pairs, four ROM bits a request
  task automatic send_responses(input logic [63:0] rom, input logic [63:0] flags,
                                input int count);
    logic [7:0] b;
    for (int j = 0; j < count; j++) begin
      for (int k = 0; k < 4; k++) begin
        b[2*k]   = flags[4*j+k];
        b[2*k+1] = rom[4*j+k];
      end
      send(ACT_RESP, b);
    end
  endtask

  task automatic run_pass(input int shape, input int count);
    logic [63:0] rom;
    logic [63:0] flags;
    rom = make_rom(shape == PASS_FAM_ZERO, shape == PASS_DISC_63);
    for (int i = 0; i < 64; i++) flags[i] = ($urandom_range(11) == 0);
    case (shape)
      PASS_LAST: begin
        flags = '0;
      end
      PASS_DISC_63: begin
        // highest flagged zero path sits at bit 62
        flags[62] = 1'b1;
        flags[63] = 1'b0;
      end
      PASS_CRC_BAD: begin
        rom[$urandom_range(63)] ^= 1'b1;
      end
      default: begin
      end
    endcase
    send(ACT_BEGIN, 8'($urandom));
    send_responses(rom, flags, count);
  endtask

  task automatic random_step();
    int pick;
    int shape;
    pick = $urandom_range(99);
    if (passes_run < 6 || pick < 80) begin
      // walk through every pass outcome once before going random
      case (passes_run)
        0: shape = PASS_DISC_63;
        1: shape = PASS_NORMAL;
        2: shape = PASS_CRC_BAD;
        3: shape = PASS_FAM_ZERO;
        4: shape = PASS_LAST;
        5: shape = PASS_NORMAL;
        default: begin
          pick = $urandom_range(99);
          if (pick < 60) shape = PASS_NORMAL;
          else if (pick < 75) shape = PASS_LAST;
          else if (pick < 85) shape = PASS_DISC_63;
          else if (pick < 95) shape = PASS_CRC_BAD;
          else shape = PASS_FAM_ZERO;
        end
      endcase
      passes_run++;
      run_pass(shape, 16);
    end else if (pick < 85) begin
      send(ACT_UNUSED, 8'($urandom));
    end else if (pick < 89) begin
      send(ACT_RESTART, 8'($urandom));
    end else if (pick < 93) begin
      send(ACT_RESP, 8'($urandom));
    end else if (pick < 96) begin
      send(ACT_BEGIN, 8'($urandom));
    end else begin
      run_pass(PASS_NORMAL, $urandom_range(15, 1));
    end
  endtask

  initial begin
    logic [63:0] rom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send(ACT_BEGIN, 8'h00);     // no discrepancy yet: all request bytes zero
    send(ACT_UNUSED, 8'hFF);
    send(ACT_RESTART, 8'hFF);
    // a full pass of responses with no begin, every zero path flagged
    rom = make_rom(1'b0, 1'b0);
    send_responses(rom, ~rom, 16);
    send(ACT_BEGIN, 8'hFF);     // requests now carry the forced path
    send(ACT_RESP, 8'h00);
    send(ACT_RESP, 8'hFF);
    send(ACT_BEGIN, 8'h00);     // drop the partial collection
    send(ACT_BEGIN, 8'h5A);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   = 32;
          recv_stall_pct = 76;
        end
        1: begin
          send_gap_pct   = 76;
          recv_stall_pct = 32;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (items_sent < 24 + (phase + 1) * ITEMS_PER_PHASE) random_step();
      drain();
    end

    // a cut-short pass may still be busy decoding
    repeat (200) @(posedge clk);
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
